[rtl/mcct_pkg.sv]
// Shared types and constants for the multi-channel compare timer.
`default_nettype none

package mcct_pkg;

    localparam int NUM_CH     = 4;
    localparam int CNT_W      = 16;
    localparam int PSC_W      = 17;
    localparam int IRQ_W      = NUM_CH + 1;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [PSC_W-1:0] PRESCALE_MAX = PSC_W'(65536);
    localparam logic [PSC_W-1:0] PRESCALE_MIN = PSC_W'(1);
    localparam int               OVF_EN_BIT   = NUM_CH;

    // transaction function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_REARM = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_PRESCALE = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_STEP_1   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_STEP_2   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_STEP_3   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_STEP_4   = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_IRQ_EN   = REG_IDX_W'(5);

    typedef struct packed {
        logic [PSC_W-1:0]               prescale;
        logic [NUM_CH-1:0][CNT_W-1:0]   step;
        logic [IRQ_W-1:0]               irq_en;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/mcct_in_if.sv]
// Input channel: tick or re-arm transactions.
`default_nettype none

interface mcct_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [1:0] channel;

    modport source (output valid, output func, output channel, input ready);
    modport sink   (input valid, input func, input channel, output ready);
endinterface

`default_nettype wire

[rtl/mcct_out_if.sv]
// Result channel: counter value and event flags.
`default_nettype none

interface mcct_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] count_value;
    logic [3:0]  match_events;
    logic        overflow_event;
    logic        irq_request;

    modport source (output valid, output count_value, output match_events,
                    output overflow_event, output irq_request, input ready);
    modport sink   (input valid, input count_value, input match_events,
                    input overflow_event, input irq_request, output ready);
endinterface

`default_nettype wire

[rtl/mcct_regs.sv]
// APB configuration register file for the compare timer.
`default_nettype none

module mcct_regs
    import mcct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [PSC_W-1:0]             prescale_reg;
    logic [NUM_CH-1:0][CNT_W-1:0] step_reg;
    logic [IRQ_W-1:0]             irq_en_reg;
    logic [REG_IDX_W-1:0]         idx;
    logic                         wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= PRESCALE_MIN;
            step_reg     <= '0;
            irq_en_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PRESCALE: prescale_reg <= pwdata[PSC_W-1:0];
                REG_STEP_1:   step_reg[0]  <= pwdata[CNT_W-1:0];
                REG_STEP_2:   step_reg[1]  <= pwdata[CNT_W-1:0];
                REG_STEP_3:   step_reg[2]  <= pwdata[CNT_W-1:0];
                REG_STEP_4:   step_reg[3]  <= pwdata[CNT_W-1:0];
                REG_IRQ_EN:   irq_en_reg   <= pwdata[IRQ_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PRESCALE: prdata = APB_DATA_W'(prescale_reg);
            REG_STEP_1:   prdata = APB_DATA_W'(step_reg[0]);
            REG_STEP_2:   prdata = APB_DATA_W'(step_reg[1]);
            REG_STEP_3:   prdata = APB_DATA_W'(step_reg[2]);
            REG_STEP_4:   prdata = APB_DATA_W'(step_reg[3]);
            REG_IRQ_EN:   prdata = APB_DATA_W'(irq_en_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.prescale = prescale_reg;
    assign cfg.step     = step_reg;
    assign cfg.irq_en   = irq_en_reg;

endmodule

`default_nettype wire

[rtl/multi_channel_compare_timer.sv]
// Top level: prescaled 16-bit counter with four output-compare channels.
`default_nettype none

// Each transaction on in_ch is a timer tick (func 0) or a re-arm of one compare
// channel (func 1, compare = count + step). Every accepted transaction yields
// exactly one result on out_ch, passing first through the input register and
// then through the result register. The block takes one transaction per clock
// while out_ch is not stalled; the counter, prescaler and compare registers are
// updated together with the result register, so back-to-back ticks see each
// other's effect. A stalled out_ch stalls in_ch through the same two registers.
// There is no post-reset initialization; registers are written over APB at
// byte address 4*index and should only be changed while no transaction is in
// flight.
module multi_channel_compare_timer
    import mcct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    mcct_in_if.sink                    in_ch,
    mcct_out_if.source                 out_ch
);

    cfg_t cfg;

    logic                         s1_valid_reg;
    logic                         s1_func_reg;
    logic [1:0]                   s1_channel_reg;

    logic [CNT_W-1:0]             psc_count_reg;
    logic [CNT_W-1:0]             psc_count_next;
    logic [CNT_W-1:0]             counter_reg;
    logic [CNT_W-1:0]             counter_next;
    logic [NUM_CH-1:0][CNT_W-1:0] compare_reg;
    logic [NUM_CH-1:0][CNT_W-1:0] compare_next;

    logic                         out_valid_reg;
    logic [CNT_W-1:0]             out_count_reg;
    logic [NUM_CH-1:0]            out_match_reg;
    logic                         out_ovf_reg;
    logic                         out_irq_reg;

    logic                         out_free;
    logic                         s1_fire;
    logic [PSC_W-1:0]             eff_prescale;
    logic [PSC_W-1:0]             psc_inc;
    logic                         advance;
    logic [CNT_W-1:0]             cnt_inc;
    logic [NUM_CH-1:0]            match_vec;
    logic                         ovf;
    logic                         irq;

    mcct_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_fire     = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_func_reg    <= in_ch.func;
            s1_channel_reg <= in_ch.channel;
        end
    end

    // zero acts as 1, anything above the maximum saturates
    always_comb
    begin
        if (cfg.prescale == '0)
        begin
            eff_prescale = PRESCALE_MIN;
        end
        else if (cfg.prescale > PRESCALE_MAX)
        begin
            eff_prescale = PRESCALE_MAX;
        end
        else
        begin
            eff_prescale = cfg.prescale;
        end
    end

    assign psc_inc = PSC_W'(psc_count_reg) + PSC_W'(1);
    assign advance = psc_inc >= eff_prescale;
    assign cnt_inc = counter_reg + CNT_W'(1);

    always_comb
    begin
        psc_count_next = psc_count_reg;
        counter_next   = counter_reg;
        compare_next   = compare_reg;
        match_vec      = '0;
        ovf            = 1'b0;
        irq            = 1'b0;
        if (s1_fire)
        begin
            if (s1_func_reg == FUNC_REARM)
            begin
                compare_next[s1_channel_reg] = counter_reg + cfg.step[s1_channel_reg];
            end
            else
            begin
                if (advance)
                begin
                    psc_count_next = '0;
                    counter_next   = cnt_inc;
                    ovf            = (cnt_inc == '0);
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (compare_reg[i] == cnt_inc)
                        begin
                            match_vec[i]    = 1'b1;
                            compare_next[i] = compare_reg[i] + cfg.step[i];
                        end
                    end
                end
                else
                begin
                    psc_count_next = psc_inc[CNT_W-1:0];
                end
                irq = (|(match_vec & cfg.irq_en[NUM_CH-1:0]))
                      || (ovf && cfg.irq_en[OVF_EN_BIT]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psc_count_reg <= '0;
            counter_reg   <= '0;
            compare_reg   <= '0;
        end
        else
        begin
            psc_count_reg <= psc_count_next;
            counter_reg   <= counter_next;
            compare_reg   <= compare_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_count_reg <= counter_next;
            out_match_reg <= match_vec;
            out_ovf_reg   <= ovf;
            out_irq_reg   <= irq;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.count_value    = out_count_reg;
    assign out_ch.match_events   = out_match_reg;
    assign out_ch.overflow_event = out_ovf_reg;
    assign out_ch.irq_request    = out_irq_reg;

endmodule

`default_nettype wire

[rtl/mcct_checker.sv]
// Port-level assertions for the compare timer, bound to the top level.
`default_nettype none

module mcct_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] count_value,
    input wire logic [3:0]  match_events,
    input wire logic        overflow_event,
    input wire logic        irq_request
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // overflow only reported on the wrap to zero
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow_event |-> count_value == 16'd0)
        else $error("overflow with nonzero count");

    // an interrupt request needs an event behind it
    a_irq_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_request |-> (match_events != 4'd0) || overflow_event)
        else $error("irq without event");

    // with the result side free, the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled with output free");

endmodule

bind multi_channel_compare_timer mcct_checker u_mcct_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .count_value    (out_ch.count_value),
    .match_events   (out_ch.match_events),
    .overflow_event (out_ch.overflow_event),
    .irq_request    (out_ch.irq_request)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the compare timer: queued ops, in-bench timer model, APB setup.
module tb_top;
    import mcct_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = REG_IDX_W'(7);

    typedef struct {
        logic       func;
        logic [1:0] channel;
        bit         drain;
    } timer_op_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count_value;
        logic [NUM_CH-1:0] match_events;
        logic              overflow_event;
        logic              irq_request;
    } timer_readout_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mcct_in_if  in_if ();
    mcct_out_if out_if ();

    multi_channel_compare_timer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    // timer model state and register copies
    logic [PSC_W-1:0]  m_prescale;
    logic [CNT_W-1:0]  m_step [NUM_CH];
    logic [IRQ_W-1:0]  m_irq_en;
    logic [CNT_W-1:0]  m_psc_cnt;
    logic [CNT_W-1:0]  m_count;
    logic [CNT_W-1:0]  m_compare [NUM_CH];

    timer_op_t      timer_ops [$];
    timer_readout_t timer_readouts [$];

    int unsigned snd_idle = 0;
    int unsigned rcv_idle = 0;
    int unsigned mismatches = 0;
    int unsigned ops_accepted = 0;
    int unsigned readouts_checked = 0;
    int unsigned reg_reads = 0;
    int unsigned match_hits = 0;
    int unsigned overflow_hits = 0;
    int unsigned irq_hits = 0;
    bit          in_fire = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void model_reset();
        int i;
        m_prescale = PRESCALE_MIN;
        m_irq_en   = '0;
        m_psc_cnt  = '0;
        m_count    = '0;
        for (i = 0; i < NUM_CH; i++)
        begin
            m_step[i]    = '0;
            m_compare[i] = '0;
        end
    endfunction

    function automatic void cfg_apply(input logic [REG_IDX_W-1:0] idx,
                                      input logic [APB_DATA_W-1:0] data);
        case (idx)
            REG_PRESCALE: m_prescale = data[PSC_W-1:0];
            REG_STEP_1:   m_step[0]  = data[CNT_W-1:0];
            REG_STEP_2:   m_step[1]  = data[CNT_W-1:0];
            REG_STEP_3:   m_step[2]  = data[CNT_W-1:0];
            REG_STEP_4:   m_step[3]  = data[CNT_W-1:0];
            REG_IRQ_EN:   m_irq_en   = data[IRQ_W-1:0];
            default:      ;
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_image(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_PRESCALE: return APB_DATA_W'(m_prescale);
            REG_STEP_1:   return APB_DATA_W'(m_step[0]);
            REG_STEP_2:   return APB_DATA_W'(m_step[1]);
            REG_STEP_3:   return APB_DATA_W'(m_step[2]);
            REG_STEP_4:   return APB_DATA_W'(m_step[3]);
            REG_IRQ_EN:   return APB_DATA_W'(m_irq_en);
            default:      return '0;
        endcase
    endfunction

    // one tick or re-arm applied to the model; returns the readout it produces
    function automatic timer_readout_t timer_advance(input logic func, input logic [1:0] channel);
        timer_readout_t r;
        int unsigned    eff;
        int             i;
        r = '0;
        if (func == FUNC_REARM)
        begin
            if (channel < NUM_CH)
                m_compare[channel] = m_count + m_step[channel];
        end
        else
        begin
            if (m_prescale == '0)
                eff = 1;
            else if (m_prescale > PRESCALE_MAX)
                eff = PRESCALE_MAX;
            else
                eff = m_prescale;
            if (int'(m_psc_cnt) + 1 >= eff)
            begin
                m_psc_cnt = '0;
                m_count   = m_count + 1'b1;
                r.overflow_event = (m_count == '0);
                for (i = 0; i < NUM_CH; i++)
                begin
                    if (m_compare[i] == m_count)
                    begin
                        r.match_events[i] = 1'b1;
                        m_compare[i] = m_compare[i] + m_step[i];
                    end
                end
            end
            else
            begin
                m_psc_cnt = m_psc_cnt + 1'b1;
            end
            r.irq_request = (|(r.match_events & m_irq_en[NUM_CH-1:0]))
                            || (r.overflow_event && m_irq_en[OVF_EN_BIT]);
        end
        r.count_value = m_count;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
        end
    endtask

    // input side: predict at acceptance
    always @(posedge clk)
    begin
        in_fire = rst_n && in_if.valid && in_if.ready;
        if (in_fire)
        begin
            timer_readouts.push_back(timer_advance(in_if.func, in_if.channel));
            ops_accepted++;
        end
    end

    always @(negedge clk)
    begin : op_driver
        logic      next_valid;
        timer_op_t op;
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
        end
        else if (!in_if.valid || in_fire)
        begin
            next_valid = 1'b0;
            if (timer_ops.size() > 0 && $urandom_range(99) >= snd_idle
                && !(timer_ops[0].drain && timer_readouts.size() > 0))
            begin
                op = timer_ops.pop_front();
                in_if.func    <= op.func;
                in_if.channel <= op.channel;
                next_valid = 1'b1;
            end
            in_if.valid <= next_valid;
        end
    end

    always @(negedge clk)
        out_if.ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin : readout_monitor
        timer_readout_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (timer_readouts.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected readout, expected none actual count 0x%0h",
                         $time, out_if.count_value);
            end
            else
            begin
                want = timer_readouts.pop_front();
                check_field("count_value", 32'(want.count_value),
                            32'(out_if.count_value));
                check_field("match_events", 32'(want.match_events),
                            32'(out_if.match_events));
                check_field("overflow_event", 32'(want.overflow_event),
                            32'(out_if.overflow_event));
                check_field("irq_request", 32'(want.irq_request),
                            32'(out_if.irq_request));
                readouts_checked++;
                if (want.match_events != '0)
                    match_hits++;
                if (want.overflow_event)
                    overflow_hits++;
                if (want.irq_request)
                    irq_hits++;
            end
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cfg_apply(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("prdata", reg_image(idx), prdata);
        reg_reads++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (timer_ops.size() > 0 || in_if.valid || timer_readouts.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_timer(input logic [31:0] psc, input logic [31:0] s1,
                                 input logic [31:0] s2, input logic [31:0] s3,
                                 input logic [31:0] s4, input logic [31:0] irq);
        logic [REG_IDX_W-1:0] idx;
        wait_quiet();
        reg_write(REG_PRESCALE, psc);
        reg_write(REG_STEP_1, s1);
        reg_write(REG_STEP_2, s2);
        reg_write(REG_STEP_3, s3);
        reg_write(REG_STEP_4, s4);
        reg_write(REG_IRQ_EN, irq);
        // unmapped indexes must not disturb anything
        reg_write(REG_SPARE_6, $urandom);
        reg_write(REG_SPARE_7, $urandom);
        for (idx = REG_PRESCALE; idx <= REG_IRQ_EN; idx++)
            reg_read_check(idx);
    endtask

    task automatic push_op(input logic func, input logic [1:0] channel, input bit drain);
        timer_op_t op;
        op.func    = func;
        op.channel = channel;
        op.drain   = drain;
        timer_ops.push_back(op);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_op(FUNC_TICK, 2'($urandom_range(3)), 1'b0);
    endtask

    function automatic logic [31:0] pick_prescale();
        logic [31:0] noise;
        noise = $urandom;
        case ($urandom_range(11))
            0:       return {noise[31:PSC_W], 17'd0};
            1:       return {noise[31:PSC_W], 17'd65536};
            2:       return {noise[31:PSC_W], 17'h1FFFF};
            3, 4:    return 32'd1;
            default: return {noise[31:PSC_W], 17'($urandom_range(1, 6))};
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        logic [31:0] noise;
        noise = $urandom;
        case ($urandom_range(7))
            0:       return {noise[31:CNT_W], 16'd0};
            1:       return {noise[31:CNT_W], 16'hFFFF};
            2:       return noise;
            default: return {noise[31:CNT_W], 16'($urandom_range(1, 12))};
        endcase
    endfunction

    // mostly re-arm followed by a run of ticks, some loose noise in between
    task automatic fill_segment(input int n);
        int added;
        int run;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                push_op(FUNC_REARM, 2'($urandom_range(3)), ($urandom_range(19) == 0));
                run = $urandom_range(1, 16);
                push_ticks(run);
                added += run + 1;
            end
            else
            begin
                run = $urandom_range(1, 4);
                repeat (run)
                    push_op($urandom_range(1) ? FUNC_REARM : FUNC_TICK,
                            2'($urandom_range(3)), 1'b0);
                added += run;
            end
        end
    endtask

    initial
    begin : main_seq
        int seg;
        int ch;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_if.valid   = 1'b0;
        in_if.func    = FUNC_TICK;
        in_if.channel = '0;
        out_if.ready  = 1'b0;
        rst_n         = 1'b0;
        model_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        snd_idle = 37;
        rcv_idle = 57;

        // directed: zero prescale acts as one, extreme steps, all irq enables
        program_timer(32'h0, 32'd3, 32'd0, 32'hFFFF, 32'd1, 32'h1F);
        for (ch = 0; ch < NUM_CH; ch++)
            push_op(FUNC_REARM, 2'(ch), 1'b0);
        push_ticks(8);
        // step zero re-arm, sent only after everything before it has drained
        push_op(FUNC_REARM, 2'd1, 1'b1);
        push_ticks(2);

        // prescale dropped below the running prescale count
        program_timer(32'd10, 32'd2, 32'd5, 32'd1, 32'd7, 32'h0F);
        push_ticks(6);
        wait_quiet();
        reg_write(REG_PRESCALE, 32'd3);
        reg_read_check(REG_PRESCALE);
        push_ticks(4);

        for (seg = 0; seg < 10; seg++)
        begin
            program_timer(pick_prescale(), pick_step(), pick_step(), pick_step(), pick_step(),
                          (seg == 0) ? 32'h1F : (seg == 1) ? 32'h0
                                     : 32'($urandom_range(31)));
            if (seg < 4)
            begin
                snd_idle = 37;
                rcv_idle = 57;
            end
            else if (seg < 7)
            begin
                snd_idle = 57;
                rcv_idle = 37;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            fill_segment(115);
        end

        // unit prescale with step zero, step 0xFFFF and step one channels
        program_timer(32'd1, 32'd0, 32'hFFFF, 32'd1, pick_step(), 32'h10);
        for (ch = 0; ch < NUM_CH; ch++)
            push_op(FUNC_REARM, 2'(ch), 1'b0);
        push_ticks(40);

        // all-ones prescale write saturates to 65536 ticks per count
        program_timer(32'hFFFF_FFFF, pick_step(), pick_step(), pick_step(), pick_step(), 32'h0F);
        push_ticks(40);

        wait_quiet();
        repeat (10) @(posedge clk);

        $display("Covered %0d tick/re-arm transactions, %0d readouts checked, %0d register reads.",
                 ops_accepted, readouts_checked, reg_reads);
        $display("Readouts with matches: %0d, overflows: %0d, interrupt requests: %0d.",
                 match_hits, overflow_hits, irq_hits);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout: %0d transactions still queued, %0d readouts outstanding.",
                 timer_ops.size(), timer_readouts.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
rtl/mcct_pkg.sv
rtl/mcct_in_if.sv
rtl/mcct_out_if.sv
rtl/mcct_regs.sv
rtl/multi_channel_compare_timer.sv
rtl/mcct_checker.sv
tb/tb_top.sv
